// ===== rtl/core/wso_pkg.sv =====
`default_nettype none

package wso_pkg;

    // sizes
    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int MAX_CHANNELS    = 8;
    localparam int ROM_SIZE        = 1 << TABLE_ADDR_BITS;
    localparam int QUARTER         = ROM_SIZE / 4;
    localparam int CH_LIMIT        = (MAX_CHANNELS < 8) ? MAX_CHANNELS : 8;
    localparam int SAMPLE_BITS     = 24;
    localparam int CODE_BITS       = 32;
    localparam int CH_BITS         = 3;
    localparam int CNT_BITS        = 4;

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // configuration register indexes
    localparam logic CFG_FORMAT   = 1'b0;
    localparam logic CFG_CHANNELS = 1'b1;

    // sample formats
    typedef enum logic [1:0] {
        FMT_F32   = 2'd0,
        FMT_I16   = 2'd1,
        FMT_I32   = 2'd2,
        FMT_U8OFS = 2'd3
    } t_fmt;

    typedef struct packed {
        t_fmt                fmt;
        logic [CNT_BITS-1:0] chans;
    } t_cfg;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef t_sample t_wave_rom [ROM_SIZE];

    // restoring unsigned division for table construction
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // sine on the quarter wave, q2.30, truncated series
    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 12; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        if (sum > longint'(Q30_ONE)) sum = longint'(Q30_ONE);
        return 64'(sum);
    endfunction

    // tanh through the exponential series, q2.30
    function automatic logic [63:0] tanh_q30(input logic [63:0] s);
        logic [63:0] y;
        logic [63:0] e;
        logic [63:0] term;
        y    = s << 1;
        e    = Q30_ONE + y;
        term = y;
        for (int n = 2; n <= 30; n++) begin
            term = ((term * y) >> 30) / 64'(n);
            e    = e + term;
        end
        return udiv64((e - Q30_ONE) << 30, e + Q30_ONE);
    endfunction

    // waveshaped sine table, q1.23, evaluated at elaboration
    function automatic t_wave_rom build_rom();
        t_wave_rom   rom;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] t;
        logic [63:0] mag;
        int          quad;
        int          r;
        for (int k = 0; k < ROM_SIZE; k++) begin
            quad = k / QUARTER;
            r    = k % QUARTER;
            if ((quad % 2) == 1) r = QUARTER - r;
            x   = (64'(r) * HALF_PI_Q30) / 64'(QUARTER);
            s   = sin_q30(x);
            t   = tanh_q30(s);
            mag = ((t * 64'd3) / 64'd5 + 64'd64) >> 7;
            if (((quad / 2) % 2) == 1) rom[k] = -SAMPLE_BITS'(mag);
            else rom[k] = SAMPLE_BITS'(mag);
        end
        return rom;
    endfunction

    localparam t_wave_rom WAVE_ROM = build_rom();

endpackage

`default_nettype wire

// ===== rtl/core/waveshaped_sine_oscillator_top.sv =====
// datapath: an accepted nonzero input reads the table into a register; the entry is encoded and
// loaded into the output register once the output channel sequencer is free
// output: the channel sequencer emits one word per cycle while m_axis_tready is high, one per
// channel (count 1 to 8); a new input is taken as its last word goes; a zero word outputs nothing
// reset: synchronous active low; phase cleared, oscillator stopped, format int16, two channels
`default_nettype none

module waveshaped_sine_oscillator_top
    import wso_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [31:0]          s_axis_tdata,  // freq_word
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [CODE_BITS-1:0]      m_axis_tdata,  // sample_code
    output logic [CH_BITS-1:0]        m_axis_tuser,  // channel_index
    output logic                      m_axis_tlast,  // last_channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic                 i_cfg_index,
    input  wire logic [3:0]           i_cfg_data
);

    t_cfg                       r_cfg;
    logic [PHASE_BITS-1:0]      r_phase;
    logic                       r_running;
    logic                       r_a_vld;
    logic [PHASE_BITS-1:0]      base;
    logic                       acc;
    logic                       acc_run;
    logic                       chan_free;
    logic [CNT_BITS-1:0]        chans_eff;
    t_sample                    rom_q;
    logic [CODE_BITS-1:0]       code;

    // configuration writes
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fmt   <= FMT_I16;
            r_cfg.chans <= 4'd2;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FORMAT:   r_cfg.fmt   <= t_fmt'(i_cfg_data[1:0]);
                CFG_CHANNELS: r_cfg.chans <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // effective channel count
    always_comb begin
        if (r_cfg.chans == '0) chans_eff = 4'd1;
        else if (r_cfg.chans > CNT_BITS'(CH_LIMIT)) chans_eff = CNT_BITS'(CH_LIMIT);
        else chans_eff = r_cfg.chans;
    end

    // input handshake
    assign s_axis_tready = !r_a_vld || chan_free;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign acc_run       = acc && (s_axis_tdata != '0);
    assign base          = r_running ? r_phase : '0;

    // phase accumulator and run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_running <= 1'b0;
        end else if (acc) begin
            if (acc_run) begin
                r_phase   <= base + PHASE_BITS'(s_axis_tdata);
                r_running <= 1'b1;
            end else begin
                r_phase   <= '0;
                r_running <= 1'b0;
            end
        end
    end

    // table read stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (acc_run) begin
            r_a_vld <= 1'b1;
        end else if (chan_free) begin
            r_a_vld <= 1'b0;
        end
    end

    wso_rom u_rom (
        .i_clk   (i_clk),
        .i_rd_en (acc_run),
        .i_addr  (base[PHASE_BITS-1 -: TABLE_ADDR_BITS]),
        .o_data  (rom_q)
    );

    wso_enc u_enc (
        .i_fmt    (r_cfg.fmt),
        .i_sample (rom_q),
        .o_code   (code)
    );

    wso_chan u_chan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (r_a_vld && chan_free),
        .i_code   (code),
        .i_chans  (chans_eff),
        .o_free   (chan_free),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_rom_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_vld && !chan_free) |=> (r_a_vld && $stable(rom_q)))
        else $error("table data lost while output busy");
    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !acc_run) |=> (!r_running && (r_phase == '0)))
        else $error("zero word did not stop the oscillator");
    a_run_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_run |=> (r_running && r_a_vld))
        else $error("nonzero word did not start a sample");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/wso_rom.sv =====
`default_nettype none

module wso_rom
    import wso_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rd_en,
    input  wire logic [TABLE_ADDR_BITS-1:0] i_addr,
    output t_sample                         o_data
);

    t_sample r_data;

    // synchronous table read, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_data <= WAVE_ROM[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ===== rtl/core/wso_enc.sv =====
`default_nettype none

module wso_enc
    import wso_pkg::*;
(
    input  t_fmt                        i_fmt,
    input  t_sample                     i_sample,
    output logic [CODE_BITS-1:0]        o_code
);

    logic                    neg;
    logic [SAMPLE_BITS-1:0]  mag;
    logic [38:0]             prod16;
    logic [15:0]             m16;
    logic [31:0]             m32;
    logic [24:0]             ofs;
    logic [7:0]              u8;
    logic [4:0]              msb;
    logic [SAMPLE_BITS-1:0]  norm;
    logic [7:0]              expo;
    logic [31:0]             f32;

    // sign and magnitude
    assign neg = i_sample[SAMPLE_BITS-1];
    assign mag = neg ? SAMPLE_BITS'(-i_sample) : SAMPLE_BITS'(i_sample);

    // int16: truncate mag*32767 / 2^23
    assign prod16 = 39'(mag) * 39'd32767;
    assign m16    = prod16[38:23];

    // int32: mag*(2^31-1) / 2^23 is mag*256-1 for nonzero mag
    assign m32 = (mag == '0) ? 32'd0 : ({mag, 8'd0} - 32'd1);

    // offset uint8
    assign ofs = {i_sample[SAMPLE_BITS-1], i_sample} + 25'h0800000;
    assign u8  = (ofs[24:16] > 9'd255) ? 8'd255 : ofs[23:16];

    // float32: leading one position and normalize
    always_comb begin
        msb = '0;
        for (int i = 0; i < SAMPLE_BITS; i++) begin
            if (mag[i]) msb = 5'(i);
        end
    end
    assign norm = mag << (5'd23 - msb);
    assign expo = 8'(msb) + 8'd104;
    assign f32  = (mag == '0) ? 32'd0 : {neg, expo, norm[22:0]};

    // format select
    always_comb begin
        unique case (i_fmt)
            FMT_F32:   o_code = f32;
            FMT_I16:   o_code = {16'd0, neg ? 16'(-m16) : m16};
            FMT_I32:   o_code = neg ? 32'(-m32) : m32;
            FMT_U8OFS: o_code = {24'd0, u8};
            default:   o_code = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/wso_chan.sv =====
`default_nettype none

module wso_chan
    import wso_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire logic [CODE_BITS-1:0] i_code,
    input  wire logic [CNT_BITS-1:0]  i_chans,
    output logic                      o_free,
    output logic                      o_tvalid,
    input  wire logic                 i_tready,
    output logic [CODE_BITS-1:0]      o_tdata,  // sample_code
    output logic [CH_BITS-1:0]        o_tuser,  // channel_index
    output logic                      o_tlast   // last_channel
);

    logic                 r_vld;
    logic [CH_BITS-1:0]   r_ch;
    logic [CODE_BITS-1:0] r_code;
    logic                 last;
    logic                 done;

    // end of the channel run
    assign last   = (({1'b0, r_ch} + 4'd1) == i_chans);
    assign done   = r_vld && i_tready && last;
    assign o_free = !r_vld || done;

    // channel sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_ch  <= '0;
        end else if (i_load) begin
            r_vld <= 1'b1;
            r_ch  <= '0;
        end else if (r_vld && i_tready) begin
            if (last) begin
                r_vld <= 1'b0;
            end else begin
                r_ch <= r_ch + 3'd1;
            end
        end
    end

    // sample word held for the whole run
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_code <= i_code;
        end
    end

    assign o_tvalid = r_vld;
    assign o_tdata  = r_code;
    assign o_tuser  = r_ch;
    assign o_tlast  = r_vld && last;

`ifndef SYNTHESIS
    a_ch_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> ({1'b0, r_ch} < i_chans))
        else $error("channel index beyond channel count");
    a_ch_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && i_tready && !last && !i_load) |=>
            (r_vld && (r_ch == $past(r_ch) + 3'd1)))
        else $error("channel did not advance after transaction");
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && !i_load) |=> !r_vld)
        else $error("output still valid after last channel");
`endif

endmodule

`default_nettype wire
